// File: hw/rtl/traffic_light_moore_fsm_unit_defines.svh
// Assertion macros for the traffic light controller.
`ifndef TRAFFIC_LIGHT_MOORE_FSM_UNIT_DEFINES_SVH
`define TRAFFIC_LIGHT_MOORE_FSM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check a property, skipped while in reset
`define TLM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tlm assertion failed");
// check a property on every edge, reset included
`define TLM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tlm assertion failed");
`else
`define TLM_ASSERT(lbl, clk, rstn, prop)
`define TLM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/tlm_pkg.sv
// Types, phase table and lookup functions for the traffic light controller.
package tlm_pkg;

    localparam int PHASE_CNT = 11;
    localparam int IDX_W     = 4;
    localparam int DWELL_W   = 10;

    localparam logic REG_LONG_DWELL  = 1'b0;
    localparam logic REG_SHORT_DWELL = 1'b1;

    localparam logic [DWELL_W-1:0] LONG_DWELL_RST  = 10'd300;
    localparam logic [DWELL_W-1:0] SHORT_DWELL_RST = 10'd20;

    typedef enum logic [PHASE_CNT-1:0] {
        PH_EW_GREEN   = 11'b000_0000_0001,
        PH_EW_YELLOW  = 11'b000_0000_0010,
        PH_NS_GREEN   = 11'b000_0000_0100,
        PH_NS_YELLOW  = 11'b000_0000_1000,
        PH_WALK       = 11'b000_0001_0000,
        PH_BLINK_OFF1 = 11'b000_0010_0000,
        PH_BLINK_ON1  = 11'b000_0100_0000,
        PH_BLINK_OFF2 = 11'b000_1000_0000,
        PH_BLINK_ON2  = 11'b001_0000_0000,
        PH_BLINK_OFF3 = 11'b010_0000_0000,
        PH_BLINK_ON3  = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        PED_DONT = 2'd0,
        PED_WALK = 2'd1,
        PED_DARK = 2'd2
    } t_ped;

    // packed from the top bit down: pattern ends up in the low bits
    typedef struct packed {
        logic             changed;
        logic [IDX_W-1:0] phase;
        logic             dont_walk;
        logic             walk;
        logic [5:0]       pattern;
    } t_result;

    localparam logic [5:0] PATTERN_TBL [0:PHASE_CNT-1] = '{
        6'h0C, 6'h14, 6'h21, 6'h22, 6'h24, 6'h24,
        6'h24, 6'h24, 6'h24, 6'h24, 6'h24
    };

    localparam t_ped PED_TBL [0:PHASE_CNT-1] = '{
        PED_DONT, PED_DONT, PED_DONT, PED_DONT, PED_WALK, PED_DARK,
        PED_WALK, PED_DARK, PED_WALK, PED_DARK, PED_WALK
    };

    // bit i set: phase i uses the long dwell
    localparam logic [PHASE_CNT-1:0] LONG_MASK = 11'b000_0001_1111;

    localparam logic [IDX_W-1:0] NEXT_TBL [0:PHASE_CNT-1][0:7] = '{
        '{4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd4, 4'd2, 4'd2},
        '{4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd2, 4'd0, 4'd2, 4'd0, 4'd4, 4'd4, 4'd4, 4'd4},
        '{4'd4, 4'd5, 4'd5, 4'd5, 4'd4, 4'd5, 4'd5, 4'd5},
        '{4'd4, 4'd6, 4'd6, 4'd6, 4'd4, 4'd6, 4'd6, 4'd6},
        '{4'd4, 4'd7, 4'd7, 4'd7, 4'd4, 4'd7, 4'd7, 4'd7},
        '{4'd4, 4'd8, 4'd8, 4'd8, 4'd4, 4'd8, 4'd8, 4'd8},
        '{4'd4, 4'd9, 4'd9, 4'd9, 4'd4, 4'd9, 4'd9, 4'd9},
        '{4'd4, 4'd10, 4'd10, 4'd10, 4'd4, 4'd10, 4'd10, 4'd10},
        '{4'd4, 4'd0, 4'd2, 4'd0, 4'd4, 4'd0, 4'd2, 4'd0}
    };

    function automatic logic [IDX_W-1:0] phase_idx(input t_phase p);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < PHASE_CNT; i++) begin
            if (p[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic t_phase phase_next(input t_phase p, input logic [2:0] det);
        logic [IDX_W-1:0] nidx;
        nidx = NEXT_TBL[phase_idx(p)][det];
        return t_phase'(PHASE_CNT'(1) << nidx);
    endfunction

endpackage

// File: hw/rtl/traffic_light_moore_fsm_unit.sv
// Traffic light controller top level: tick input, phase FSM, lamp result output.
//
//  channel   | dir | word
//  s_axis    | in  | one 10 ms tick with detector bits
//  m_axis    | out | lamp pattern, phase and change flag of that tick
//  apb       | cfg | long and short dwell registers
//
// One tick per cycle sustained while m_axis is ready: input register, then phase
// lookup and dwell compare into the result register.
// The input register can fill while a result waits on m_axis, but holds a buffered tick until the result is taken.
// Reset puts the FSM in east-west green with a zero dwell count and loads
// the dwell registers with 300 and 20 ticks.
`include "traffic_light_moore_fsm_unit_defines.svh"

module traffic_light_moore_fsm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [2:0] detectors, [7:3] zero

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [5:0] light_pattern, [6] walk_lamp,
                                          // [7] dont_walk_lamp, [11:8] phase,
                                          // [12] changed, [15:13] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [tlm_pkg::DWELL_W-1:0] r_long_dwell;
    logic [tlm_pkg::DWELL_W-1:0] r_short_dwell;

    logic                        r_in_valid;
    logic [2:0]                  r_in_det;

    tlm_pkg::t_phase             r_phase;
    tlm_pkg::t_phase             n_phase;
    logic [tlm_pkg::DWELL_W-1:0] r_dwell;
    logic [tlm_pkg::DWELL_W-1:0] n_dwell;

    logic                        r_out_valid;
    tlm_pkg::t_result            r_out;
    tlm_pkg::t_result            n_out;

    logic                        advance;
    logic                        in_acc;
    logic                        cfg_wr;
    logic [tlm_pkg::DWELL_W-1:0] dwell;
    logic [tlm_pkg::DWELL_W:0]   cnt_inc;
    logic                        dwell_end;
    logic [tlm_pkg::IDX_W-1:0]   nidx;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr          = psel && penable && pwrite && pready;
    assign pready          = 1'b1;

    always_comb begin
        unique case (paddr[2])
            tlm_pkg::REG_LONG_DWELL:  prdata = {22'd0, r_long_dwell};
            tlm_pkg::REG_SHORT_DWELL: prdata = {22'd0, r_short_dwell};
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        dwell = (tlm_pkg::LONG_MASK[tlm_pkg::phase_idx(r_phase)]) ? r_long_dwell
                                                                   : r_short_dwell;
        if (dwell == '0) begin
            dwell = tlm_pkg::DWELL_W'(1);
        end
        cnt_inc   = {1'b0, r_dwell} + (tlm_pkg::DWELL_W+1)'(1);
        dwell_end = cnt_inc >= {1'b0, dwell};
        if (dwell_end) begin
            n_phase = tlm_pkg::phase_next(r_phase, r_in_det);
            n_dwell = '0;
        end else begin
            n_phase = r_phase;
            n_dwell = cnt_inc[tlm_pkg::DWELL_W-1:0];
        end
        nidx              = tlm_pkg::phase_idx(n_phase);
        n_out.pattern     = tlm_pkg::PATTERN_TBL[nidx];
        n_out.walk        = tlm_pkg::PED_TBL[nidx] == tlm_pkg::PED_WALK;
        n_out.dont_walk   = tlm_pkg::PED_TBL[nidx] == tlm_pkg::PED_DONT;
        n_out.phase       = nidx;
        n_out.changed     = dwell_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_dwell  <= tlm_pkg::LONG_DWELL_RST;
            r_short_dwell <= tlm_pkg::SHORT_DWELL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                tlm_pkg::REG_LONG_DWELL:  r_long_dwell  <= pwdata[tlm_pkg::DWELL_W-1:0];
                tlm_pkg::REG_SHORT_DWELL: r_short_dwell <= pwdata[tlm_pkg::DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= tlm_pkg::PH_EW_GREEN;
            r_dwell     <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_dwell     <= n_dwell;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_det <= i_s_axis_tdata[2:0];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out};

    // while valid, the result register shows the phase now held by the FSM
    `TLM_ASSERT(a_out_phase_sync, i_clk, i_rst_n, r_out_valid |-> (r_out.phase == tlm_pkg::phase_idx(r_phase)))
    // a phase change restarts the dwell count
    `TLM_ASSERT(a_change_clears, i_clk, i_rst_n, (r_out_valid && r_out.changed) |-> (r_dwell == '0))
    // without a change the count has moved past zero
    `TLM_ASSERT(a_hold_counts, i_clk, i_rst_n, (r_out_valid && !r_out.changed) |-> (r_dwell != '0))
    // a buffered tick is kept while the result side stalls
    `TLM_ASSERT(a_in_kept, i_clk, i_rst_n, (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_det)))

endmodule
